// File: rtl/core/tkwp_pkg.sv
// shared types, constants and helpers of the top-k list with weighted pick
`default_nettype none

package tkwp_pkg;

   // default sizes
   localparam int KEEP_DEF     = 80;
   localparam int PICK_CAP_DEF = 20;

   // field widths
   localparam int MODE_W  = 2;
   localparam int COORD_W = 12;
   localparam int SCORE_W = 16;
   localparam int RND_W   = 32;
   localparam int OCNT_W  = 7;

   // item modes
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PICK   = 2'd2;

   // pick window narrowing
   localparam int NARROW_FROM = 10;
   localparam int NARROW_MIN  = 5;

   // n / 10 as (n * 205) >> 11, exact for any 9-bit n
   localparam int DIV10_IN_W  = 9;
   localparam int DIV10_MUL   = 205;
   localparam int DIV10_SHIFT = 11;
   localparam int DIV10_P_W   = 18;

   typedef struct packed {
      logic [COORD_W-1:0]        x;
      logic [COORD_W-1:0]        y;
      logic signed [SCORE_W-1:0] score;
   } entry_type;

   typedef struct packed {
      logic ins_en;
      logic rot_en;
   } cell_ctl_type;

   typedef struct packed {
      logic               done;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } pick_res_type;

   typedef struct packed {
      logic               ok;
      logic [COORD_W-1:0] pick_x;
      logic [COORD_W-1:0] pick_y;
      logic [OCNT_W-1:0]  entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      PK_IDLE,
      PK_SCAN,
      PK_TOTAL,
      PK_MOD,
      PK_WALK,
      PK_DONE
   } pick_state_type;

   function automatic logic [DIV10_IN_W-1:0] div10(input logic [DIV10_IN_W-1:0] n);
      logic [DIV10_P_W-1:0] p;
      p = DIV10_P_W'(n) * DIV10_P_W'(DIV10_MUL);
      return DIV10_IN_W'(p >> DIV10_SHIFT);
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/tkwp_channels.sv
// valid/ready channel interfaces for items in and results out
`default_nettype none

interface tkwp_req_if;
   logic                               valid;
   logic                               ready;
   logic [tkwp_pkg::MODE_W-1:0]        mode;
   logic [tkwp_pkg::COORD_W-1:0]       in_x;
   logic [tkwp_pkg::COORD_W-1:0]       in_y;
   logic signed [tkwp_pkg::SCORE_W-1:0] in_score;
   logic [tkwp_pkg::RND_W-1:0]         random_word;

   modport source (output valid, mode, in_x, in_y, in_score, random_word, input ready);
   modport sink   (input valid, mode, in_x, in_y, in_score, random_word, output ready);
endinterface

interface tkwp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [tkwp_pkg::COORD_W-1:0]  pick_x;
   logic [tkwp_pkg::COORD_W-1:0]  pick_y;
   logic [tkwp_pkg::OCNT_W-1:0]   entry_count;

   modport source (output valid, ok, pick_x, pick_y, entry_count, input ready);
   modport sink   (input valid, ok, pick_x, pick_y, entry_count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tkwp_cell.sv
// one list cell: holds an entry, inserts by shifting, rotates for a pick scan
`default_nettype none

module tkwp_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 7
) (
   input  wire                       clock,
   input  tkwp_pkg::cell_ctl_type    ctl,
   input  wire [CNT_W-1:0]           held_count,
   input  tkwp_pkg::entry_type       new_ent,
   input  wire                       prev_ge,
   input  tkwp_pkg::entry_type       left_ent,
   input  tkwp_pkg::entry_type       right_ent,
   output tkwp_pkg::entry_type       ent,
   output logic                      ge
);

   tkwp_pkg::entry_type ent_ff;
   tkwp_pkg::entry_type ent_in;

   // held and at least as good as the new entry: the new one goes below
   assign ge = (CNT_W'(IDX) < held_count) &&
               ($signed(ent_ff.score) >= $signed(new_ent.score));

   always_comb begin
      ent_in = ent_ff;
      if (ctl.rot_en) begin
         ent_in = right_ent;
      end else if (ctl.ins_en) begin
         if (ge) begin
            ent_in = ent_ff;
         end else if (prev_ge) begin
            ent_in = new_ent;
         end else begin
            ent_in = left_ent;
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent = ent_ff;

endmodule

`default_nettype wire

// File: rtl/core/tkwp_pick.sv
// weighted pick sequencer: scan sum, total, bit-serial modulo, weight walk
`default_nettype none

module tkwp_pick #(
   parameter int KEEP     = tkwp_pkg::KEEP_DEF,
   parameter int PICK_CAP = tkwp_pkg::PICK_CAP_DEF,
   parameter int CNT_W    = $clog2(KEEP + 1)
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   input  wire [CNT_W-1:0]               held_count,
   input  wire [tkwp_pkg::RND_W-1:0]     random_word,
   input  tkwp_pkg::entry_type           head,
   output logic                          rot_en,
   output logic                          busy,
   output tkwp_pkg::pick_res_type        res
);

   localparam int LIM_W = $clog2(PICK_CAP + 1);
   localparam int ROT_W = (KEEP > 1) ? $clog2(KEEP) : 1;
   localparam int CW    = ((ROT_W > LIM_W) ? ROT_W : LIM_W) + 1;
   localparam int LW    = ((CNT_W > LIM_W) ? CNT_W : LIM_W) + 4;
   localparam int SUM_W = tkwp_pkg::SCORE_W + 1 + LIM_W;
   localparam int TOT_W = tkwp_pkg::SCORE_W + LIM_W;
   localparam int PRD_W = LIM_W + tkwp_pkg::SCORE_W + 1;
   localparam int XW    = SUM_W + LIM_W + 2;
   localparam int BIT_W = $clog2(tkwp_pkg::RND_W);
   localparam int W_W   = tkwp_pkg::SCORE_W + 2;

   tkwp_pkg::pick_state_type state_ff, state_in;

   logic [ROT_W-1:0]                 step_ff;
   logic [BIT_W-1:0]                 bit_ff;
   logic [LIM_W-1:0]                 limit_ff;
   logic signed [SUM_W-1:0]          sum_ff;
   logic signed [tkwp_pkg::SCORE_W-1:0] lowest_ff;
   logic [TOT_W-1:0]                 total_ff;
   logic [TOT_W-1:0]                 rem_ff;
   logic [tkwp_pkg::RND_W-1:0]       rnd_ff;
   logic                             found_ff;
   logic [tkwp_pkg::COORD_W-1:0]     x_ff;
   logic [tkwp_pkg::COORD_W-1:0]     y_ff;

   // window size
   logic [LW-1:0] cnt_x, lim_a, narrow, lim_b;

   always_comb begin
      cnt_x  = LW'(held_count);
      lim_a  = (cnt_x < LW'(PICK_CAP)) ? cnt_x : LW'(PICK_CAP);
      narrow = LW'(tkwp_pkg::div10(tkwp_pkg::DIV10_IN_W'(held_count)));
      if (narrow < LW'(tkwp_pkg::NARROW_MIN)) begin
         narrow = LW'(tkwp_pkg::NARROW_MIN);
      end
      lim_b = lim_a;
      if ((cnt_x >= LW'(tkwp_pkg::NARROW_FROM)) && (narrow < lim_a)) begin
         lim_b = narrow;
      end
   end

   logic step_end, bit_end, step_in_win, step_at_low;

   assign step_end    = (step_ff == ROT_W'(KEEP - 1));
   assign bit_end     = (bit_ff == BIT_W'(tkwp_pkg::RND_W - 1));
   assign step_in_win = (CW'(step_ff) < CW'(limit_ff));
   assign step_at_low = ((CW'(step_ff) + CW'(1)) == CW'(limit_ff));

   // total weight = sum - limit * lowest + limit
   logic signed [LIM_W:0]   lim_s;
   logic signed [PRD_W-1:0] prod;
   logic signed [XW-1:0]    tot_x;

   always_comb begin
      lim_s = {1'b0, limit_ff};
      prod  = lim_s * lowest_ff;
      tot_x = XW'(sum_ff) - XW'(prod) + XW'(lim_s);
   end

   // one restoring step of random_word mod total
   logic [TOT_W:0] rem_sh, rem_sub;
   logic [TOT_W-1:0] rem_step;

   always_comb begin
      rem_sh   = {rem_ff, rnd_ff[tkwp_pkg::RND_W-1]};
      rem_sub  = rem_sh - {1'b0, total_ff};
      rem_step = (rem_sh >= {1'b0, total_ff}) ? TOT_W'(rem_sub) : TOT_W'(rem_sh);
   end

   // weight of the head entry
   logic signed [W_W-1:0] w_s;
   logic [TOT_W-1:0]      w;

   always_comb begin
      w_s = W_W'($signed(head.score)) - W_W'(lowest_ff) + W_W'(1);
      w   = TOT_W'(w_s[W_W-2:0]);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tkwp_pkg::PK_IDLE:  if (start)    state_in = tkwp_pkg::PK_SCAN;
         tkwp_pkg::PK_SCAN:  if (step_end) state_in = tkwp_pkg::PK_TOTAL;
         tkwp_pkg::PK_TOTAL: state_in = tkwp_pkg::PK_MOD;
         tkwp_pkg::PK_MOD:   if (bit_end)  state_in = tkwp_pkg::PK_WALK;
         tkwp_pkg::PK_WALK:  if (step_end) state_in = tkwp_pkg::PK_DONE;
         tkwp_pkg::PK_DONE:  state_in = tkwp_pkg::PK_IDLE;
         default:            state_in = tkwp_pkg::PK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rot_en   = 1'b0;
      busy     = 1'b1;
      res.done = 1'b0;
      res.x    = x_ff;
      res.y    = y_ff;
      unique case (state_ff)
         tkwp_pkg::PK_IDLE: busy     = 1'b0;
         tkwp_pkg::PK_SCAN: rot_en   = 1'b1;
         tkwp_pkg::PK_WALK: rot_en   = 1'b1;
         tkwp_pkg::PK_DONE: res.done = 1'b1;
         default:           busy     = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tkwp_pkg::PK_IDLE;
         step_ff  <= '0;
         bit_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            tkwp_pkg::PK_IDLE: begin
               step_ff  <= '0;
               bit_ff   <= '0;
               found_ff <= 1'b0;
            end
            tkwp_pkg::PK_SCAN:  step_ff <= step_end ? '0 : step_ff + ROT_W'(1);
            tkwp_pkg::PK_MOD:   bit_ff  <= bit_ff + BIT_W'(1);
            tkwp_pkg::PK_WALK: begin
               step_ff <= step_end ? '0 : step_ff + ROT_W'(1);
               if (step_in_win && !found_ff && (rem_ff < w)) begin
                  found_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         tkwp_pkg::PK_IDLE: begin
            limit_ff <= LIM_W'(lim_b);
            rnd_ff   <= random_word;
            sum_ff   <= '0;
         end
         tkwp_pkg::PK_SCAN: begin
            if (step_in_win) begin
               sum_ff <= sum_ff + SUM_W'($signed(head.score));
            end
            if (step_at_low) begin
               lowest_ff <= head.score;
            end
         end
         tkwp_pkg::PK_TOTAL: begin
            total_ff <= TOT_W'(tot_x);
            rem_ff   <= '0;
         end
         tkwp_pkg::PK_MOD: begin
            rem_ff <= rem_step;
            rnd_ff <= {rnd_ff[tkwp_pkg::RND_W-2:0], 1'b0};
         end
         tkwp_pkg::PK_WALK: begin
            if (step_in_win && !found_ff) begin
               if (rem_ff < w) begin
                  x_ff <= head.x;
                  y_ff <= head.y;
               end else begin
                  rem_ff <= rem_ff - w;
               end
            end
         end
         default: begin
         end
      endcase
   end

   a_mod_rem_below_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tkwp_pkg::PK_MOD) |-> (rem_ff < total_ff))
      else $error("modulo remainder reached the total weight");

   a_walk_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tkwp_pkg::PK_WALK) |-> (total_ff != '0))
      else $error("weight walk with zero total");

   a_done_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tkwp_pkg::PK_DONE) |-> found_ff)
      else $error("weight walk ended without a choice");

endmodule

`default_nettype wire

// File: rtl/core/tkwp_rspq.sv
// two-slot result queue driving the result channel
`default_nettype none

module tkwp_rspq (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  tkwp_pkg::rsp_type   push_data,
   output logic                space,
   tkwp_rsp_if.source          rsp_if
);

   localparam int DEPTH = 2;

   tkwp_pkg::rsp_type slot_ff [DEPTH];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop                = rsp_if.valid && rsp_if.ready;
   assign space              = (cnt_ff < 2'(DEPTH));
   assign rsp_if.valid       = (cnt_ff != 2'd0);
   assign rsp_if.ok          = slot_ff[rd_ff].ok;
   assign rsp_if.pick_x      = slot_ff[rd_ff].pick_x;
   assign rsp_if.pick_y      = slot_ff[rd_ff].pick_y;
   assign rsp_if.entry_count = slot_ff[rd_ff].entry_count;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> ((cnt_ff != 2'(DEPTH)) || pop))
      else $error("result queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(DEPTH))
      else $error("result queue count out of range");

   a_pop_follows: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (cnt_ff == $past(cnt_ff) - 2'd1))
      else $error("result queue count did not drop after a pop");

endmodule

`default_nettype wire

// File: rtl/core/top_k_list_weighted_pick_core.sv
// top level: sorted top-k cell chain with weighted pick and result queue
//
// channel   dir  handshake          payload
// req_if    in   valid/ready        mode, in_x, in_y, in_score, random_word
// rsp_if    out  valid/ready        ok, pick_x, pick_y, entry_count
//
// clear, insert, unknown mode and pick on an empty list: one item per cycle
//   while no pick runs and the result queue has space; the whole chain
//   shifts in parallel to open the slot for an insert
// pick: acceptance, a full ring rotation for the sum scan, the total, the 32-step
//   bit-serial modulo, a second rotation for the weight walk, the result hand-off
// reset clears the count, the pick sequencer and the result queue; entries are
//   left as they are and only entries below the count are ever read
// a two-slot result queue lets the next item in while a result waits
`default_nettype none

module top_k_list_weighted_pick_core #(
   parameter int KEEP     = tkwp_pkg::KEEP_DEF,
   parameter int PICK_CAP = tkwp_pkg::PICK_CAP_DEF
) (
   input  wire         clock,
   input  wire         reset,
   tkwp_req_if.sink    req_if,
   tkwp_rsp_if.source  rsp_if
);

   localparam int CNT_W = $clog2(KEEP + 1);

   logic [CNT_W-1:0] held_count_ff, held_count_in;

   tkwp_pkg::entry_type    ent      [KEEP];
   tkwp_pkg::entry_type    left_ent [KEEP];
   logic [KEEP-1:0]        ge;
   logic [KEEP-1:0]        prev_ge;
   tkwp_pkg::entry_type    new_ent;
   tkwp_pkg::cell_ctl_type cell_ctl;

   tkwp_pkg::pick_res_type pick_res;
   tkwp_pkg::rsp_type      push_data;
   logic                   pick_busy, pick_rot, pick_start;
   logic                   q_space, push;

   logic req_fire, full, beats_last, kept;

   assign req_fire     = req_if.valid && req_if.ready;
   assign req_if.ready = !pick_busy && q_space;

   assign new_ent.x     = req_if.in_x;
   assign new_ent.y     = req_if.in_y;
   assign new_ent.score = req_if.in_score;

   // a full list only takes a score strictly above its last entry
   assign full       = (held_count_ff == CNT_W'(KEEP));
   assign beats_last = ($signed(req_if.in_score) > $signed(ent[KEEP-1].score));
   assign kept       = !full || beats_last;

   assign pick_start = req_fire && (req_if.mode == tkwp_pkg::MODE_PICK) &&
                       (held_count_ff != '0);

   assign cell_ctl.rot_en = pick_rot;
   assign cell_ctl.ins_en = req_fire && (req_if.mode == tkwp_pkg::MODE_INSERT) && kept;

   // cell chain: each cell sees its upper neighbor for inserts and its
   // lower neighbor for the ring rotation that feeds the pick sequencer
   for (genvar i = 0; i < KEEP; i++) begin : g_cell
      localparam int NXT = (i + 1) % KEEP;
      if (i == 0) begin : g_head
         assign prev_ge[i]  = 1'b1;
         assign left_ent[i] = new_ent;
      end else begin : g_body
         assign prev_ge[i]  = ge[i-1];
         assign left_ent[i] = ent[i-1];
      end
      tkwp_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .held_count (held_count_ff),
         .new_ent    (new_ent),
         .prev_ge    (prev_ge[i]),
         .left_ent   (left_ent[i]),
         .right_ent  (ent[NXT]),
         .ent        (ent[i]),
         .ge         (ge[i])
      );
   end

   tkwp_pick #(
      .KEEP     (KEEP),
      .PICK_CAP (PICK_CAP),
      .CNT_W    (CNT_W)
   ) u_pick (
      .clock       (clock),
      .reset       (reset),
      .start       (pick_start),
      .held_count  (held_count_ff),
      .random_word (req_if.random_word),
      .head        (ent[0]),
      .rot_en      (pick_rot),
      .busy        (pick_busy),
      .res         (pick_res)
   );

   // count update and result for items finished on acceptance and for finished picks
   always_comb begin
      held_count_in         = held_count_ff;
      push                  = 1'b0;
      push_data.ok          = 1'b0;
      push_data.pick_x      = '0;
      push_data.pick_y      = '0;
      push_data.entry_count = tkwp_pkg::OCNT_W'(held_count_ff);
      if (pick_res.done) begin
         push             = 1'b1;
         push_data.ok     = 1'b1;
         push_data.pick_x = pick_res.x;
         push_data.pick_y = pick_res.y;
      end else if (req_fire) begin
         push = !pick_start;
         unique case (req_if.mode)
            tkwp_pkg::MODE_CLEAR: begin
               held_count_in = '0;
               push_data.ok  = 1'b1;
            end
            tkwp_pkg::MODE_INSERT: begin
               push_data.ok = kept;
               if (!full) begin
                  held_count_in = held_count_ff + CNT_W'(1);
               end
            end
            default: push_data.ok = 1'b0;
         endcase
         push_data.entry_count = tkwp_pkg::OCNT_W'(held_count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
      end else begin
         held_count_ff <= held_count_in;
      end
   end

   tkwp_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .space     (q_space),
      .rsp_if    (rsp_if)
   );

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_if.mode == tkwp_pkg::MODE_CLEAR)) |=> (held_count_ff == '0))
      else $error("clear did not empty the list");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_if.mode == tkwp_pkg::MODE_INSERT) && !full)
      |=> (held_count_ff == $past(held_count_ff) + CNT_W'(1)))
      else $error("insert into a non-full list did not grow the count");

   a_no_accept_in_pick: assert property (@(posedge clock) disable iff (reset)
      pick_busy |-> !req_if.ready)
      else $error("item accepted during a pick");

   a_count_held_in_pick: assert property (@(posedge clock) disable iff (reset)
      (pick_busy && $past(pick_busy)) |-> $stable(held_count_ff))
      else $error("count moved during a pick");

endmodule

`default_nettype wire

// File: dv/tb_top_k_list_weighted_pick_core.sv
// testbench of the top-k sorted list with weighted pick: random and directed items, scoreboard
`timescale 1ns / 100ps

module tb_top_k_list_weighted_pick_core;
   import tkwp_pkg::*;

   localparam int KEEP     = KEEP_DEF;
   localparam int PICK_CAP = PICK_CAP_DEF;

   // mode 3 has no meaning, the block must leave the list alone
   localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;

   // counted items of the random part
   localparam int RANDOM_ITEMS = 950;
   // settle time after the last owed result, leaves room for stray results
   localparam int SETTLE_CYCLES = 2 * KEEP + 60;
   // worst case is well under a quarter of this
   localparam longint RUN_LIMIT_NS = 64'd12_000_000;

   typedef struct {
      logic [MODE_W-1:0]         mode;
      logic [COORD_W-1:0]        x;
      logic [COORD_W-1:0]        y;
      logic signed [SCORE_W-1:0] score;
      logic [RND_W-1:0]          rnd;
      int unsigned               gap;
      bit                        drain_first;
   } list_item_type;

   typedef enum logic [1:0] {
      SCORE_WIDE,
      SCORE_BAND,
      SCORE_EXTREME
   } score_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tkwp_req_if req_if ();
   tkwp_rsp_if rsp_if ();

   top_k_list_weighted_pick_core #(
      .KEEP     (KEEP),
      .PICK_CAP (PICK_CAP)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // items waiting to go in, results owed by the block
   list_item_type queued_items[$];
   rsp_type       due_rsps[$];
   int            fail_count = 0;

   // shadow copy of the sorted list
   logic [COORD_W-1:0] list_x[KEEP];
   logic [COORD_W-1:0] list_y[KEEP];
   int                 list_score[KEEP];
   int unsigned        held_n = 0;

   // generator state
   bit              sender_bursty;
   score_style_type style;
   int              band_base;
   int              counted;
   int              target;
   int              i;
   bit              drain_next;

   // driver and monitor state
   bit          offering = 1'b0;
   bit          gap_armed = 1'b0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned rsp_seen = 0;
   bit          take_rsp;
   rsp_type     want;

   // weight of one entry in the pick window, never below 1
   function automatic int unsigned pick_weight(input int s, input int lo);
      int w;
      w = s - lo + 1;
      return (w < 1) ? 1 : w;
   endfunction

   // advance the shadow list by one accepted item and queue the result it owes
   function automatic void apply_to_list(input list_item_type it);
      rsp_type     r;
      int unsigned lim;
      int unsigned narrow;
      int unsigned total;
      int unsigned roll;
      int unsigned w;
      int          lowest;
      int          pos;
      bit          found;
      r = '0;
      case (it.mode)
         MODE_CLEAR: begin
            held_n = 0;
            r.ok = 1'b1;
         end
         MODE_INSERT: begin
            // full list: a score that does not beat the tail is dropped
            if (held_n >= KEEP && int'(it.score) <= list_score[KEEP-1]) begin
               r.ok = 1'b0;
            end else begin
               if (held_n < KEEP) held_n++;
               pos = held_n - 1;
               // strictly lower scores move down, equal scores stay ahead
               while (pos > 0 && list_score[pos-1] < int'(it.score)) begin
                  list_x[pos]     = list_x[pos-1];
                  list_y[pos]     = list_y[pos-1];
                  list_score[pos] = list_score[pos-1];
                  pos--;
               end
               list_x[pos]     = it.x;
               list_y[pos]     = it.y;
               list_score[pos] = int'(it.score);
               r.ok = 1'b1;
            end
         end
         MODE_PICK: begin
            if (held_n != 0) begin
               lim = (held_n < PICK_CAP) ? held_n : PICK_CAP;
               if (held_n >= NARROW_FROM) begin
                  narrow = held_n / 10;
                  if (narrow < NARROW_MIN) narrow = NARROW_MIN;
                  if (narrow < lim) lim = narrow;
               end
               lowest = list_score[lim-1];
               total = 0;
               for (int k = 0; k < lim; k++) total += pick_weight(list_score[k], lowest);
               roll = it.rnd % total;
               found = 1'b0;
               for (int k = 0; k < lim && !found; k++) begin
                  w = pick_weight(list_score[k], lowest);
                  if (roll < w) begin
                     r.pick_x = list_x[k];
                     r.pick_y = list_y[k];
                     found = 1'b1;
                  end else begin
                     roll -= w;
                  end
               end
               // walk ran off the end, head entry wins
               if (!found) begin
                  r.pick_x = list_x[0];
                  r.pick_y = list_y[0];
               end
               r.ok = 1'b1;
            end
         end
         default: r.ok = 1'b0;
      endcase
      r.entry_count = OCNT_W'(held_n);
      due_rsps.push_back(r);
   endfunction

   function automatic void queue_item(input logic [MODE_W-1:0] mode,
                                      input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y,
                                      input logic signed [SCORE_W-1:0] score,
                                      input logic [RND_W-1:0] rnd,
                                      input bit drain_first);
      list_item_type it;
      it.mode        = mode;
      it.x           = x;
      it.y           = y;
      it.score       = score;
      it.rnd         = rnd;
      it.gap         = sender_bursty ? 0 : $urandom_range(0, 19);
      it.drain_first = drain_first;
      queued_items.push_back(it);
   endfunction

   // random word for a pick, with the edge values now and then
   function automatic logic [RND_W-1:0] draw_roll();
      case ($urandom_range(0, 7))
         0:       return RND_W'($urandom_range(0, 3));
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic signed [SCORE_W-1:0] draw_score(input score_style_type st,
                                                             input int base);
      int v;
      case (st)
         SCORE_BAND: begin
            // tight band around a base value, lots of ties
            v = base + int'($urandom_range(0, 8)) - 4;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[SCORE_W-1:0];
         end
         SCORE_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       return 16'sh8000;
               1:       return -16'sd1;
               2:       return 16'sd0;
               3:       return 16'sd1;
               default: return 16'sh7fff;
            endcase
         end
         default: return SCORE_W'($urandom());
      endcase
   endfunction

   // driver: present queued items, predict on each accepted one
   always @(posedge clock) begin
      if (reset) begin
         offering  = 1'b0;
         gap_armed = 1'b0;
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            apply_to_list(queued_items.pop_front());
            offering  = 1'b0;
            gap_armed = 1'b0;
         end
         if (!offering && queued_items.size() != 0) begin
            if (!gap_armed) begin
               gap_left  = queued_items[0].gap;
               gap_armed = 1'b1;
            end
            if (gap_left != 0) begin
               gap_left--;
            end else if (!(queued_items[0].drain_first && due_rsps.size() != 0)) begin
               // drain_first items wait until the block owes nothing
               offering = 1'b1;
               req_if.mode        <= queued_items[0].mode;
               req_if.in_x        <= queued_items[0].x;
               req_if.in_y        <= queued_items[0].y;
               req_if.in_score    <= queued_items[0].score;
               req_if.random_word <= queued_items[0].rnd;
            end
         end
         req_if.valid <= offering;
      end
   end

   // monitor: random back-pressure, in-order compare against owed results
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_rsps.size() == 0) begin
               $error("result with nothing owed: ok=%0d x=%0d y=%0d count=%0d",
                      rsp_if.ok, rsp_if.pick_x, rsp_if.pick_y, rsp_if.entry_count);
               fail_count++;
            end else begin
               want = due_rsps.pop_front();
               if (rsp_if.ok !== want.ok) begin
                  $error("ok: expected %0d, got %0d", want.ok, rsp_if.ok);
                  fail_count++;
               end
               if (rsp_if.pick_x !== want.pick_x) begin
                  $error("pick_x: expected %0d, got %0d", want.pick_x, rsp_if.pick_x);
                  fail_count++;
               end
               if (rsp_if.pick_y !== want.pick_y) begin
                  $error("pick_y: expected %0d, got %0d", want.pick_y, rsp_if.pick_y);
                  fail_count++;
               end
               if (rsp_if.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, rsp_if.entry_count);
                  fail_count++;
               end
            end
            rsp_seen++;
            // one stretch in three takes every result at once
            stall_left = ((rsp_seen / 48) % 3 == 0) ? 0 : $urandom_range(0, 19);
         end
         if (stall_left != 0) begin
            stall_left--;
            take_rsp = 1'b0;
         end else begin
            take_rsp = 1'b1;
         end
         rsp_if.ready <= take_rsp;
      end
   end

   initial begin
      req_if.valid       = 1'b0;
      req_if.mode        = MODE_CLEAR;
      req_if.in_x        = '0;
      req_if.in_y        = '0;
      req_if.in_score    = '0;
      req_if.random_word = '0;
      rsp_if.ready       = 1'b0;

      // directed: empty pick, unknown mode, extreme fields, ties, edge rolls
      sender_bursty = 1'b0;
      queue_item(MODE_PICK, 12'd0, 12'd0, 16'sd0, 32'd0, 1'b0);
      queue_item(MODE_UNKNOWN, 12'hfff, 12'hfff, 16'sh7fff, '1, 1'b0);
      queue_item(MODE_INSERT, 12'd0, 12'd0, 16'sd0, 32'd0, 1'b0);
      queue_item(MODE_INSERT, 12'hfff, 12'hfff, 16'sh7fff, '1, 1'b0);
      queue_item(MODE_INSERT, 12'habc, 12'h543, 16'sh8000, 32'd0, 1'b0);
      // equal scores land behind the ones already held
      queue_item(MODE_INSERT, 12'd1, 12'd2, 16'sd0, 32'd0, 1'b0);
      queue_item(MODE_INSERT, 12'd3, 12'd4, 16'sd0, 32'd0, 1'b0);
      queue_item(MODE_PICK, 12'd0, 12'd0, 16'sd0, 32'd0, 1'b0);
      queue_item(MODE_PICK, 12'd0, 12'd0, 16'sd0, '1, 1'b0);
      queue_item(MODE_UNKNOWN, 12'd5, 12'd6, 16'sd7, 32'd8, 1'b0);
      queue_item(MODE_PICK, 12'd0, 12'd0, 16'sd0, $urandom(), 1'b0);
      queue_item(MODE_INSERT, 12'h555, 12'haaa, 16'sh7fff, 32'd0, 1'b0);
      queue_item(MODE_INSERT, 12'haaa, 12'h555, -16'sd1, 32'd0, 1'b0);
      queue_item(MODE_PICK, 12'd0, 12'd0, 16'sd0, 32'd1, 1'b0);
      queue_item(MODE_PICK, 12'd0, 12'd0, 16'sd0, 32'd65536, 1'b0);
      queue_item(MODE_CLEAR, 12'd0, 12'd0, 16'sd0, 32'd0, 1'b0);
      // sender holds off here until every owed result is back
      queue_item(MODE_PICK, 12'hfff, 12'hfff, 16'sd0, '1, 1'b1);
      queue_item(MODE_INSERT, 12'h800, 12'h001, 16'sh8000, 32'd0, 1'b0);
      queue_item(MODE_PICK, 12'd0, 12'd0, 16'sd0, '1, 1'b0);
      queue_item(MODE_CLEAR, 12'hfff, 12'hfff, 16'sh7fff, '1, 1'b0);

      // random rounds: mostly a clear, fill to a drawn size with picks mixed in, then a few picks
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         sender_bursty = ($urandom_range(0, 3) == 0);
         style         = score_style_type'($urandom_range(0, 2));
         band_base     = int'($urandom_range(0, 65535)) - 32768;
         drain_next    = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) != 0) begin
            queue_item(MODE_CLEAR, COORD_W'($urandom_range(0, 4095)),
                       COORD_W'($urandom_range(0, 4095)),
                       SCORE_W'($urandom()), $urandom(), drain_next);
            drain_next = 1'b0;
            counted++;
         end
         // mostly short lists, some near full, some that overflow
         case ($urandom_range(0, 19))
            0, 1, 2:       target = $urandom_range(80, 140);
            3, 4, 5, 6, 7: target = $urandom_range(31, 79);
            default:       target = $urandom_range(1, 30);
         endcase
         for (i = 0; i < target && counted < RANDOM_ITEMS; i++) begin
            queue_item(MODE_INSERT, COORD_W'($urandom_range(0, 4095)),
                       COORD_W'($urandom_range(0, 4095)),
                       draw_score(style, band_base), $urandom(), drain_next);
            drain_next = 1'b0;
            counted++;
            if ($urandom_range(0, 5) == 0) begin
               queue_item(MODE_PICK, COORD_W'($urandom_range(0, 4095)),
                          COORD_W'($urandom_range(0, 4095)),
                          SCORE_W'($urandom()), draw_roll(), 1'b0);
               counted++;
            end
            // stray unknown mode, not counted
            if ($urandom_range(0, 79) == 0)
               queue_item(MODE_UNKNOWN, COORD_W'($urandom_range(0, 4095)),
                          COORD_W'($urandom_range(0, 4095)),
                          SCORE_W'($urandom()), $urandom(), 1'b0);
         end
         repeat ($urandom_range(1, 4)) begin
            queue_item(MODE_PICK, COORD_W'($urandom_range(0, 4095)),
                       COORD_W'($urandom_range(0, 4095)),
                       SCORE_W'($urandom()), draw_roll(), 1'b0);
            counted++;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // everything sent and every owed result back, then watch for strays
      while (queued_items.size() != 0 || offering || due_rsps.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top_k_list_weighted_pick_core: PASS");
      else
         $display("tb_top_k_list_weighted_pick_core: FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("tb_top_k_list_weighted_pick_core: FAIL");
      $finish;
   end

endmodule
